### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bmp pixel to glyph converter
// depth codes, register indexes, batch record and palette lookup
// ----------------------------------------------------------------------------
package bpa_pkg;

    // image size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W   = 11;                       // width/height register
    localparam int COL_W   = $clog2(MAX_WIDTH + 1);    // pixel column, holds width itself
    localparam int ROW_W   = $clog2(MAX_HEIGHT);       // data row
    localparam int TCOL_W  = 11;                       // text column field
    localparam int TROW_W  = 10;                       // text row field
    localparam int NPIX    = 8;                        // most pixels from one byte
    localparam int NPIX_W  = $clog2(NPIX + 1);
    localparam int KIDX_W  = $clog2(2 * NPIX);

    // depth codes
    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_4  = 3'd1;
    localparam logic [2:0] DEPTH_8  = 3'd2;
    localparam logic [2:0] DEPTH_24 = 3'd3;
    localparam logic [2:0] DEPTH_32 = 3'd4;

    // register indexes
    localparam logic [2:0] REG_DEPTH   = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_PAL_SEL = 3'd3;
    localparam logic [2:0] REG_PAL_REV = 3'd4;

    // palette codes
    localparam logic [1:0] PAL_GRAD16 = 2'd0;
    localparam logic [1:0] PAL_SET_A  = 2'd1;
    localparam logic [1:0] PAL_SET_B  = 2'd2;
    localparam logic [1:0] PAL_BLOCKS = 2'd3;

    // 1-bit glyphs
    localparam logic [7:0] GLYPH_SET   = 8'h20;
    localparam logic [7:0] GLYPH_CLEAR = 8'hDB;

    typedef struct packed {
        logic [2:0]       depth_mode;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [1:0]       palette_select;
        logic             palette_reverse;
    } t_cfg;

    // pixels of one byte, ready to be sent out as glyph pairs
    typedef struct packed {
        logic [NPIX-1:0][7:0] glyphs;    // first pixel in entry 0
        logic [NPIX_W-1:0]    npix;      // 1 to NPIX
        logic [TROW_W-1:0]    text_row;
        logic [TCOL_W-1:0]    col2;      // text column of first glyph
        logic                 eoi;       // last pixel ends the image
    } t_batch;

    function automatic logic [7:0] pal_grad16(input logic [3:0] idx);
        logic [7:0] g;
        unique case (idx)
            4'd0:  g = " ";
            4'd1:  g = ".";
            4'd2:  g = ":";
            4'd3:  g = "!";
            4'd4:  g = "/";
            4'd5:  g = "r";
            4'd6:  g = "l";
            4'd7:  g = "1";
            4'd8:  g = "Z";
            4'd9:  g = "4";
            4'd10: g = "H";
            4'd11: g = "9";
            4'd12: g = "W";
            4'd13: g = "8";
            4'd14: g = "$";
            default: g = "@";
        endcase
        return g;
    endfunction

    function automatic logic [7:0] pal_set_a(input logic [2:0] idx);
        logic [7:0] g;
        unique case (idx)
            3'd0: g = " ";
            3'd1: g = ".";
            3'd2: g = ":";
            3'd3: g = "^";
            3'd4: g = "u";
            3'd5: g = "w";
            3'd6: g = "U";
            default: g = "W";
        endcase
        return g;
    endfunction

    function automatic logic [7:0] pal_set_b(input logic [2:0] idx);
        logic [7:0] g;
        unique case (idx)
            3'd0: g = " ";
            3'd1: g = ".";
            3'd2: g = ":";
            3'd3: g = "^";
            3'd4: g = "r";
            3'd5: g = "a";
            3'd6: g = "A";
            default: g = "R";
        endcase
        return g;
    endfunction

    function automatic logic [7:0] pal_blocks(input logic [1:0] idx);
        logic [7:0] g;
        unique case (idx)
            2'd0: g = 8'h20;
            2'd1: g = 8'hB0;
            2'd2: g = 8'hB2;
            default: g = 8'hDB;
        endcase
        return g;
    endfunction

    // level 0..15 to glyph; reversing is a bit flip of the index
    function automatic logic [7:0] level_glyph(input logic [3:0] level,
                                               input logic [1:0] sel,
                                               input logic       rev);
        logic [3:0] idx;
        logic [7:0] g;
        idx = rev ? ~level : level;
        unique case (sel)
            PAL_GRAD16: g = pal_grad16(idx);
            PAL_SET_A:  g = pal_set_a(idx[3:1]);
            PAL_SET_B:  g = pal_set_b(idx[3:1]);
            default:    g = pal_blocks(idx[3:2]);
        endcase
        return g;
    endfunction

    // channel sum / 48 as (sum >> 4) / 3 by reciprocal multiply, low 4 bits
    function automatic logic [3:0] sum_level(input logic [9:0] sum);
        logic [5:0]  q16;
        logic [13:0] prod;
        q16  = sum[9:4];
        prod = {8'd0, q16} * 14'd171;
        return prod[12:9];
    endfunction

endpackage

### src/bpa_decode.sv
// ----------------------------------------------------------------------------
// bpa_decode: byte walker and pixel decoder
// tracks pixel phase, column, row and row padding; turns a byte into a batch
// ----------------------------------------------------------------------------
module bpa_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpa_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_slot_free,
    output logic            o_batch_valid,
    output bpa_pkg::t_batch o_batch
);
    import bpa_pkg::*;

    logic [1:0]       r_phase, n_phase;
    logic [9:0]       r_sum, n_sum;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_pad, n_pad;
    logic             r_bvalid;
    t_batch           r_batch, n_batch;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DIM_W-1:0] row0, row1, row_nx, pad_row_nx;
    logic [COL_W-1:0] col0, col_end, rem;
    logic [1:0]       ph_eff, pad_new;
    logic [9:0]       sum_eff, sum_add;
    logic [NPIX_W-1:0] npix;
    logic [NPIX-1:0][7:0] glyphs;
    logic             produce, accept;
    logic [DIM_W:0]   bytes_lo;

    // clamp size registers
    always_comb begin
        if (i_cfg.image_width == '0)
            w_eff = DIM_W'(1);
        else if (i_cfg.image_width > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = i_cfg.image_width;
        if (i_cfg.image_height == '0)
            h_eff = DIM_W'(1);
        else if (i_cfg.image_height > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = i_cfg.image_height;
    end

    // channel accumulation with stale phase restart
    assign ph_eff  = (r_phase == 2'd3) ? 2'd0 : r_phase;
    assign sum_eff = (r_phase == 2'd3) ? 10'd0 : r_sum;
    assign sum_add = sum_eff + {2'd0, i_byte};

    // does this byte make pixels (independent of its value)
    always_comb begin
        if (r_pad != 2'd0)
            produce = 1'b0;
        else if (i_cfg.depth_mode == DEPTH_24)
            produce = (ph_eff == 2'd2);
        else if (i_cfg.depth_mode == DEPTH_32)
            produce = (r_phase == 2'd3);
        else
            produce = 1'b1;
    end

    assign o_ready = !produce || i_slot_free;
    assign accept  = i_valid && o_ready;

    // row and column position before this byte's pixels
    always_comb begin
        row0 = (DIM_W'(r_row) >= h_eff) ? '0 : DIM_W'(r_row);
        if (DIM_W'(r_col) >= w_eff) begin
            col0 = '0;
            row1 = (row0 + DIM_W'(1) >= h_eff) ? '0 : row0 + DIM_W'(1);
        end else begin
            col0 = r_col;
            row1 = row0;
        end
        row_nx     = (row1 + DIM_W'(1) >= h_eff) ? '0 : row1 + DIM_W'(1);
        pad_row_nx = (DIM_W'(r_row) + DIM_W'(1) >= h_eff) ? '0
                                                           : DIM_W'(r_row) + DIM_W'(1);
        rem        = COL_W'(w_eff) - col0;
    end

    // pixel count and glyphs per depth
    always_comb begin
        glyphs = '0;
        npix   = NPIX_W'(1);
        unique case (i_cfg.depth_mode)
            DEPTH_1: begin
                npix = (rem >= COL_W'(NPIX)) ? NPIX_W'(NPIX) : NPIX_W'(rem);
                for (int i = 0; i < NPIX; i++)
                    glyphs[i] = i_byte[7-i] ? GLYPH_SET : GLYPH_CLEAR;
            end
            DEPTH_4: begin
                npix = (col0 + COL_W'(1) < COL_W'(w_eff)) ? NPIX_W'(2) : NPIX_W'(1);
                glyphs[0] = level_glyph(i_byte[7:4], i_cfg.palette_select,
                                        i_cfg.palette_reverse);
                glyphs[1] = level_glyph(i_byte[3:0], i_cfg.palette_select,
                                        i_cfg.palette_reverse);
            end
            DEPTH_24: begin
                glyphs[0] = level_glyph(sum_level(sum_add), i_cfg.palette_select,
                                        i_cfg.palette_reverse);
            end
            DEPTH_32: begin
                glyphs[0] = level_glyph(sum_level(r_sum), i_cfg.palette_select,
                                        i_cfg.palette_reverse);
            end
            default: begin
                glyphs[0] = level_glyph(i_byte[7:4], i_cfg.palette_select,
                                        i_cfg.palette_reverse);
            end
        endcase
        col_end = col0 + (produce ? COL_W'(npix) : COL_W'(0));
    end

    // padding after a row: low two bits of the row byte count
    always_comb begin
        unique case (i_cfg.depth_mode)
            DEPTH_1:  bytes_lo = ({1'b0, w_eff} + (DIM_W + 1)'(7)) >> 3;
            DEPTH_4:  bytes_lo = ({1'b0, w_eff} + (DIM_W + 1)'(1)) >> 1;
            DEPTH_24: bytes_lo = {1'b0, w_eff} + {w_eff, 1'b0};
            DEPTH_32: bytes_lo = '0;
            default:  bytes_lo = {1'b0, w_eff};
        endcase
        pad_new = 2'd0 - bytes_lo[1:0];
    end

    // state update
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_col   = r_col;
        n_row   = r_row;
        n_pad   = r_pad;
        n_batch.glyphs   = glyphs;
        n_batch.npix     = npix;
        n_batch.text_row = TROW_W'(h_eff - DIM_W'(1) - row1);
        n_batch.col2     = TCOL_W'({col0, 1'b0});
        n_batch.eoi      = (row1 + DIM_W'(1) == h_eff) && (col_end == COL_W'(w_eff));
        if (accept) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
                if (r_pad == 2'd1) begin
                    n_col = '0;
                    n_row = ROW_W'(pad_row_nx);
                end
            end else begin
                // channel state
                if (i_cfg.depth_mode == DEPTH_24) begin
                    if (ph_eff == 2'd2) begin
                        n_phase = 2'd0;
                        n_sum   = '0;
                    end else begin
                        n_phase = ph_eff + 2'd1;
                        n_sum   = sum_add;
                    end
                end else if (i_cfg.depth_mode == DEPTH_32) begin
                    if (r_phase == 2'd3) begin
                        n_phase = 2'd0;
                        n_sum   = '0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                        n_sum   = r_sum + {2'd0, i_byte};
                    end
                end
                // position and row end
                if (col_end >= COL_W'(w_eff)) begin
                    if (pad_new == 2'd0) begin
                        n_col = '0;
                        n_row = ROW_W'(row_nx);
                    end else begin
                        n_col = col_end;
                        n_row = ROW_W'(row1);
                        n_pad = pad_new;
                    end
                end else begin
                    n_col = col_end;
                    n_row = ROW_W'(row1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_sum    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
            r_bvalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
            r_bvalid <= accept && produce;
        end
    end

    // batch payload
    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_batch <= n_batch;
        end
    end

    assign o_batch_valid = r_bvalid;
    assign o_batch       = r_batch;

    // a byte taken during row padding never makes pixels
    a_pad_no_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> !produce)
        else $error("pixel byte decoded while row padding pending");

    a_phase_24: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cfg.depth_mode == DEPTH_24 && r_pad == 2'd0) |=> (r_phase != 2'd3))
        else $error("24-bit pixel phase out of range");

    a_row_end_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_pad == 2'd1) |=> (r_col == '0))
        else $error("column not cleared after row padding");

endmodule

### src/bpa_emit.sv
// ----------------------------------------------------------------------------
// bpa_emit: glyph serializer
// holds one pixel batch and sends each glyph twice; while i_ready is high, one result a cycle
// ----------------------------------------------------------------------------
module bpa_emit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_batch_valid,
    input  bpa_pkg::t_batch         i_batch,
    output logic                    o_slot_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_glyph,
    output logic [bpa_pkg::TROW_W-1:0] o_text_row,
    output logic [bpa_pkg::TCOL_W-1:0] o_text_column,
    output logic                    o_last,
    output logic                    o_eoi
);
    import bpa_pkg::*;

    logic              r_valid;
    logic [KIDX_W-1:0] r_k;
    t_batch            r_b;
    logic              last_k, take;

    // result index within the batch
    assign last_k = ({1'b0, r_k} == {r_b.npix, 1'b0} - (KIDX_W + 1)'(1));
    assign take   = r_valid && i_ready;

    // a batch still in the handoff register claims the slot
    assign o_slot_free = !i_batch_valid && (!r_valid || (take && last_k));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (i_batch_valid) begin
            r_valid <= 1'b1;
            r_k     <= '0;
        end else if (take) begin
            if (last_k) begin
                r_valid <= 1'b0;
            end
            r_k <= r_k + KIDX_W'(1);
        end
    end

    // batch payload
    always_ff @(posedge i_clk) begin
        if (i_batch_valid) begin
            r_b <= i_batch;
        end
    end

    // result fields
    assign o_valid       = r_valid;
    assign o_glyph       = r_b.glyphs[r_k[KIDX_W-1:1]];
    assign o_text_row    = r_b.text_row;
    assign o_text_column = r_b.col2 + TCOL_W'(r_k);
    assign o_last        = last_k;
    assign o_eoi         = r_b.eoi && last_k;

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_k} < {r_b.npix, 1'b0}))
        else $error("glyph index past batch end");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_batch_valid |-> $past(o_slot_free))
        else $error("batch loaded over pending glyphs");

    a_eoi_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_eoi) |-> o_last)
        else $error("end of image not on last glyph of a byte");

    a_hold_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !last_k) |=> r_valid)
        else $error("batch dropped before all glyphs sent");

endmodule

### src/bmp_pixel_to_ascii_glyph_top.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_ascii_glyph_top: bmp pixel array bytes to text glyph stream
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       one pixel-array byte
//   m_axis    out        m_axis_tvalid/tready       glyph, row, column, flags
//   cfg       in         i_cfg_valid/o_cfg_ready    register index, data
//
// a padding or partial-pixel byte is taken every cycle; a byte that makes
// pixels goes to the batch register the next cycle and to the serializer the
// cycle after, where its first glyph is shown. each pixel is sent as two
// glyphs, one result a cycle while m_axis is ready, 2 to 16 results per byte
// through the single result port; the output idles during the handoff
// between pixel bytes. the next byte is taken on the cycle the last glyph of
// the held batch leaves. synchronous active-low reset clears position state
// and loads register defaults; no clearing pass. a stall on m_axis holds the
// batch and backs up s_axis only for pixel bytes.
// ----------------------------------------------------------------------------
module bmp_pixel_to_ascii_glyph_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] pixel_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] glyph, [17:8] text_row,
                                         // [28:18] text_column, [31:29] zero
    output logic        m_axis_tlast,    // last_of_item
    output logic        m_axis_tuser,    // end_of_image
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import bpa_pkg::*;

    t_cfg              r_cfg;
    t_batch            batch;
    logic              batch_valid, slot_free;
    logic [7:0]        glyph;
    logic [TROW_W-1:0] text_row;
    logic [TCOL_W-1:0] text_column;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode      <= DEPTH_24;
            r_cfg.image_width     <= DIM_W'(1);
            r_cfg.image_height    <= DIM_W'(1);
            r_cfg.palette_select  <= PAL_GRAD16;
            r_cfg.palette_reverse <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEPTH:   r_cfg.depth_mode      <= i_cfg_data[2:0];
                REG_WIDTH:   r_cfg.image_width     <= i_cfg_data;
                REG_HEIGHT:  r_cfg.image_height    <= i_cfg_data;
                REG_PAL_SEL: r_cfg.palette_select  <= i_cfg_data[1:0];
                REG_PAL_REV: r_cfg.palette_reverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte walker
    bpa_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_slot_free   (slot_free),
        .o_batch_valid (batch_valid),
        .o_batch       (batch)
    );

    // glyph serializer
    bpa_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch_valid (batch_valid),
        .i_batch       (batch),
        .o_slot_free   (slot_free),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_glyph       (glyph),
        .o_text_row    (text_row),
        .o_text_column (text_column),
        .o_last        (m_axis_tlast),
        .o_eoi         (m_axis_tuser)
    );

    assign m_axis_tdata = {3'd0, text_column, text_row, glyph};

endmodule

### tb/sv/tb_bmp_pixel_to_ascii_glyph_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_to_ascii_glyph_top: self-checking bench for the bmp glyph converter
// feeds pixel-array bytes under random stalls on both streams, predicts every
// glyph with its row, column and flags, and checks the output stream in order
// ----------------------------------------------------------------------------
module tb_bmp_pixel_to_ascii_glyph_top;
    import bpa_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_BYTES  = 290;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int MAX_REPORTS   = 50;

    // palettes, entry 0 first
    localparam logic [0:15][7:0] GRAD16_GLYPHS = " .:!/rl1Z4H9W8$@";
    localparam logic [0:7][7:0]  SET_A_GLYPHS  = " .:^uwUW";
    localparam logic [0:7][7:0]  SET_B_GLYPHS  = " .:^raAR";
    localparam logic [0:3][7:0]  BLOCK_GLYPHS  = {8'h20, 8'hB0, 8'hB2, 8'hDB};

    typedef struct packed {
        logic [7:0]  glyph;
        logic [9:0]  text_row;
        logic [10:0] text_col;
        logic        item_last;
        logic        image_end;
    } t_glyph_cell;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_DEPTH;
    logic [10:0] i_cfg_data = 11'd0;

    logic [7:0]  pixel_queue[$];
    t_glyph_cell glyph_expect[$];
    logic        byte_taken = 1'b0;
    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;
    int          error_count = 0;
    int          bytes_taken = 0;
    int          glyphs_checked = 0;
    int          reg_writes = 0;
    int          setups = 0;

    // predicted register file and position state
    logic [2:0]  cfg_depth;
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [1:0]  cfg_pal;
    logic        cfg_rev;
    int          px_phase;
    int          chan_sum;
    int          px_col;
    int          data_row_idx;
    int          pad_remaining;

    bmp_pixel_to_ascii_glyph_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
        error_count++;
    endtask

    // zero is taken as one, oversize as the maximum
    function automatic int eff_dim(input logic [10:0] v, input int max_v);
        if (v == 11'd0) return 1;
        if (int'(v) > max_v) return max_v;
        return int'(v);
    endfunction

    function automatic int row_data_bytes(input logic [2:0] depth, input int w);
        case (depth)
            DEPTH_1:  return (w + 7) / 8;
            DEPTH_4:  return (w + 1) / 2;
            DEPTH_24: return 3 * w;
            DEPTH_32: return 4 * w;
            default:  return w;
        endcase
    endfunction

    // 32-bit rows are never padded
    function automatic int row_pad_bytes(input logic [2:0] depth, input int w);
        if (depth == DEPTH_32) return 0;
        return (4 - (row_data_bytes(depth, w) % 4)) % 4;
    endfunction

    function automatic logic [7:0] glyph_of_level(input logic [3:0] level);
        int len;
        int idx;
        case (cfg_pal)
            PAL_GRAD16: len = 16;
            PAL_BLOCKS: len = 4;
            default:    len = 8;
        endcase
        idx = (int'(level) * len) / 16;
        if (cfg_rev) idx = len - 1 - idx;
        case (cfg_pal)
            PAL_GRAD16: return GRAD16_GLYPHS[idx];
            PAL_SET_A:  return SET_A_GLYPHS[idx];
            PAL_SET_B:  return SET_B_GLYPHS[idx];
            default:    return BLOCK_GLYPHS[idx];
        endcase
    endfunction

    function automatic void next_row(input int h);
        px_col = 0;
        data_row_idx++;
        if (data_row_idx >= h) data_row_idx = 0;
    endfunction

    // one pixel covers two text columns
    function automatic void push_pixel_pair(input logic [7:0] glyph, input int w, input int h);
        t_glyph_cell pix;
        for (int half = 0; half < 2; half++) begin
            pix.glyph     = glyph;
            pix.text_row  = 10'(h - 1 - data_row_idx);
            pix.text_col  = 11'(2 * px_col + half);
            pix.item_last = 1'b0;
            pix.image_end = (half == 1) && (data_row_idx + 1 == h) && (px_col + 1 == w);
            glyph_expect.push_back(pix);
        end
        px_col++;
    endfunction

    // expected glyphs for one accepted pixel-array byte
    function automatic void absorb_byte(input logic [7:0] b);
        int w;
        int h;
        int n_before;
        int pad;
        w = eff_dim(cfg_width, MAX_WIDTH);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        n_before = glyph_expect.size();
        // padding bytes make nothing; the last one closes the row
        if (pad_remaining > 0) begin
            pad_remaining--;
            if (pad_remaining == 0) next_row(h);
            return;
        end
        // a shrunken size ends the row or wraps the image first
        if (data_row_idx >= h) data_row_idx = 0;
        if (px_col >= w) next_row(h);
        case (cfg_depth)
            DEPTH_1: begin
                for (int bit_i = 7; bit_i >= 0 && px_col < w; bit_i--) begin
                    push_pixel_pair(b[bit_i] ? GLYPH_SET : GLYPH_CLEAR, w, h);
                end
            end
            DEPTH_4: begin
                push_pixel_pair(glyph_of_level(b[7:4]), w, h);
                if (px_col < w) push_pixel_pair(glyph_of_level(b[3:0]), w, h);
            end
            DEPTH_24: begin
                if (px_phase >= 3) begin
                    px_phase = 0;
                    chan_sum = 0;
                end
                chan_sum = (chan_sum + b) & 1023;
                if (px_phase == 2) begin
                    push_pixel_pair(glyph_of_level(4'(chan_sum / 48)), w, h);
                    px_phase = 0;
                    chan_sum = 0;
                end else begin
                    px_phase++;
                end
            end
            DEPTH_32: begin
                // alpha adds nothing but releases the pixel
                if (px_phase < 3) chan_sum = (chan_sum + b) & 1023;
                if (px_phase == 3) begin
                    push_pixel_pair(glyph_of_level(4'(chan_sum / 48)), w, h);
                    px_phase = 0;
                    chan_sum = 0;
                end else begin
                    px_phase++;
                end
            end
            default: push_pixel_pair(glyph_of_level(b[7:4]), w, h);
        endcase
        // row end: either padding follows or the next row starts
        if (px_col >= w) begin
            pad = row_pad_bytes(cfg_depth, w);
            if (pad == 0) next_row(h);
            else pad_remaining = pad;
        end
        if (glyph_expect.size() > n_before) begin
            glyph_expect[glyph_expect.size() - 1].item_last = 1'b1;
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_DEPTH:   cfg_depth  = val[2:0];
            REG_WIDTH:   cfg_width  = val;
            REG_HEIGHT:  cfg_height = val;
            REG_PAL_SEL: cfg_pal    = val[1:0];
            REG_PAL_REV: cfg_rev    = val[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every request and glyph to clear, then let the pipeline settle
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        while ((pixel_queue.size() != 0 || s_axis_tvalid || glyph_expect.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (glyph_expect.size() != 0) begin
            report_mismatch($sformatf("%0d expected glyphs never arrived, first %02h",
                                      glyph_expect.size(), glyph_expect[0].glyph));
            glyph_expect.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver: new byte or idle at the falling edge; sink ready drawn at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || byte_taken) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
                    s_axis_tdata  <= pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor: predict on accepted bytes, check accepted glyphs
    always @(posedge i_clk) begin : monitor
        t_glyph_cell want;
        t_glyph_cell got;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                byte_taken = 1'b1;
                bytes_taken++;
                absorb_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.glyph     = m_axis_tdata[7:0];
                got.text_row  = m_axis_tdata[17:8];
                got.text_col  = m_axis_tdata[28:18];
                got.item_last = m_axis_tlast;
                got.image_end = m_axis_tuser;
                glyphs_checked++;
                if (glyph_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected glyph %02h row %0d col %0d",
                                              got.glyph, got.text_row, got.text_col));
                end else begin
                    want = glyph_expect.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            "glyph %02h/%02h row %0d/%0d col %0d/%0d last %b/%b end %b/%b",
                            got.glyph, want.glyph, got.text_row, want.text_row,
                            got.text_col, want.text_col, got.item_last, want.item_last,
                            got.image_end, want.image_end));
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d glyphs outstanding", glyph_expect.size());
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus and phase control
    initial begin : stimulus
        int random_sent;
        int img_bytes;
        int w_eff;
        int h_eff;
        int pick;
        bit first_setup;
        logic [7:0] b;

        cfg_depth     = DEPTH_24;
        cfg_width     = 11'd1;
        cfg_height    = 11'd1;
        cfg_pal       = PAL_GRAD16;
        cfg_rev       = 1'b0;
        px_phase      = 0;
        chan_sum      = 0;
        px_col        = 0;
        data_row_idx  = 0;
        pad_remaining = 0;
        random_sent   = 0;
        first_setup   = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_gap_pct    = 13;
        sink_stall_pct = 60;

        // one 24-bit pixel at reset defaults, its padding byte wraps the image
        pixel_queue = '{8'hFF, 8'hFF, 8'hFF, 8'hAA};
        drain_and_settle();

        // 1-bit, 9 pixels a row: bits past the row end are dropped
        write_reg(REG_DEPTH, 11'(DEPTH_1));
        write_reg(REG_WIDTH, 11'd9);
        pixel_queue = '{8'hA5, 8'h7F, 8'h00, 8'hFF};
        drain_and_settle();

        // 4-bit odd width: low nibble of the last data byte dropped, reversed set
        write_reg(REG_DEPTH, 11'(DEPTH_4));
        write_reg(REG_WIDTH, 11'd3);
        write_reg(REG_PAL_SEL, 11'(PAL_SET_A));
        write_reg(REG_PAL_REV, 11'd1);
        pixel_queue = '{8'h0F, 8'hA5, 8'h11, 8'h22};
        drain_and_settle();

        // unused depth code acts as 8-bit, zero width taken as one
        write_reg(REG_DEPTH, 11'd7);
        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_PAL_SEL, 11'(PAL_BLOCKS));
        write_reg(REG_PAL_REV, 11'd0);
        pixel_queue = '{8'hF0, 8'h00, 8'hFF, 8'h5A};
        drain_and_settle();

        // 32-bit pixel released on the alpha byte, zero height taken as one
        write_reg(REG_DEPTH, 11'(DEPTH_32));
        write_reg(REG_WIDTH, 11'd1);
        write_reg(REG_HEIGHT, 11'd0);
        write_reg(REG_PAL_SEL, 11'(PAL_SET_B));
        pixel_queue = '{8'h10, 8'h20, 8'h30, 8'h77};
        drain_and_settle();

        // oversize image, depth switched in the middle of a pixel
        write_reg(REG_DEPTH, 11'(DEPTH_24));
        write_reg(REG_WIDTH, 11'd2047);
        write_reg(REG_HEIGHT, 11'd2047);
        write_reg(REG_PAL_SEL, 11'(PAL_GRAD16));
        pixel_queue = '{8'hFF, 8'h80};
        drain_and_settle();
        write_reg(REG_DEPTH, 11'(DEPTH_32));
        pixel_queue = '{8'h40, 8'hC3};
        drain_and_settle();

        // random setups: mostly whole small images, some cut short
        while (random_sent < RANDOM_BYTES) begin
            if (random_sent < RANDOM_BYTES / 3) begin
                src_gap_pct    = 13;
                sink_stall_pct = 60;
            end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
                src_gap_pct    = 60;
                sink_stall_pct = 13;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            drain_and_settle();

            if (first_setup || $urandom_range(1) == 0) begin
                if ($urandom_range(9) < 8) write_reg(REG_DEPTH, 11'($urandom_range(0, 4)));
                else write_reg(REG_DEPTH, 11'($urandom_range(5, 7)));
            end
            if (first_setup || $urandom_range(1) == 0) begin
                pick = $urandom_range(19);
                if (pick < 15)       write_reg(REG_WIDTH, 11'($urandom_range(1, 12)));
                else if (pick == 15) write_reg(REG_WIDTH, 11'd0);
                else if (pick == 16) write_reg(REG_WIDTH, 11'd1024);
                else if (pick == 17) write_reg(REG_WIDTH, 11'd2047);
                else if (pick == 18) write_reg(REG_WIDTH, 11'd1023);
                else                 write_reg(REG_WIDTH, 11'($urandom_range(0, 2047)));
            end
            if (first_setup || $urandom_range(1) == 0) begin
                pick = $urandom_range(19);
                if (pick < 16)       write_reg(REG_HEIGHT, 11'($urandom_range(1, 3)));
                else if (pick == 16) write_reg(REG_HEIGHT, 11'd0);
                else if (pick == 17) write_reg(REG_HEIGHT, 11'd1024);
                else if (pick == 18) write_reg(REG_HEIGHT, 11'd2047);
                else                 write_reg(REG_HEIGHT, 11'($urandom_range(0, 2047)));
            end
            if (first_setup || $urandom_range(1) == 0) begin
                write_reg(REG_PAL_SEL, 11'($urandom_range(0, 3)));
            end
            if (first_setup || $urandom_range(1) == 0) begin
                write_reg(REG_PAL_REV, 11'($urandom_range(0, 1)));
            end
            first_setup = 1'b0;

            w_eff = eff_dim(cfg_width, MAX_WIDTH);
            h_eff = eff_dim(cfg_height, MAX_HEIGHT);
            img_bytes = h_eff * (row_data_bytes(cfg_depth, w_eff)
                                 + row_pad_bytes(cfg_depth, w_eff));
            // large images and a share of the rest are cut short
            if (img_bytes > 64 || $urandom_range(4) == 0) img_bytes = $urandom_range(1, 24);
            // keep the total near the planned byte count
            if (img_bytes > RANDOM_BYTES - random_sent) img_bytes = RANDOM_BYTES - random_sent;
            repeat (img_bytes) begin
                pick = $urandom_range(7);
                if (pick == 0)      b = 8'h00;
                else if (pick == 1) b = 8'hFF;
                else                b = 8'($urandom_range(255));
                pixel_queue.push_back(b);
            end
            random_sent += img_bytes;
            setups++;
        end
        drain_and_settle();

        $display("covered %0d pixel bytes and %0d checked glyphs", bytes_taken, glyphs_checked);
        $display("over %0d random setups and %0d register writes", setups, reg_writes);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
